[rtl/core/pso_peu_pkg.sv]
// ----------------------------------------------------------------------------
// pso_peu_pkg
// shared types, register indexes and helpers for the particle element update
// ----------------------------------------------------------------------------
package pso_peu_pkg;

	localparam int unsigned SigW   = 32;  // Q16.16 signals
	localparam int unsigned CoefW  = 16;  // Q4.12 weights and gains
	localparam int unsigned RandW  = 16;  // Q0.16 randoms
	localparam int unsigned FracSh = 12;  // Q4.12 fraction bits
	localparam int unsigned DiffW  = SigW + 1;
	localparam int unsigned InProdW = CoefW + SigW;              // w*v
	localparam int unsigned InTermW = InProdW - FracSh;          // w*v >>> 12
	localparam int unsigned AtProdW = CoefW + 1 + DiffW;         // f*(y-x)
	localparam int unsigned AtTermW = AtProdW - FracSh;          // f*(y-x) >>> 12
	localparam int unsigned SumW    = AtTermW + 1;
	localparam int unsigned CfgIdxW = 8;

	localparam logic signed [CoefW-1:0] InertiaRst = 16'sd2867;
	localparam logic [CoefW-1:0]        CogRst     = 16'd8192;
	localparam logic [CoefW-1:0]        SocRst     = 16'd8192;

	typedef enum logic [CfgIdxW-1:0] {
		REG_INERTIA = 8'd0,
		REG_COG     = 8'd1,
		REG_SOC     = 8'd2
	} cfg_reg_t;

	typedef struct packed {
		logic signed [SigW-1:0] position;
		logic signed [SigW-1:0] velocity;
		logic signed [SigW-1:0] personal_best;
		logic signed [SigW-1:0] global_best;
		logic [RandW-1:0]       rand_one;
		logic [RandW-1:0]       rand_two;
		logic signed [SigW-1:0] lower_bound;
		logic signed [SigW-1:0] upper_bound;
		logic                   last_element;
	} in_item_t;

	typedef struct packed {
		logic signed [SigW-1:0] position;
		logic signed [SigW-1:0] new_velocity;
		logic signed [SigW-1:0] lower_bound;
		logic signed [SigW-1:0] upper_bound;
		logic                   last_element;
	} vel_item_t;

	typedef struct packed {
		logic adv_s1;
		logic adv_s2;
		logic adv_s3;
	} pipe_ctrl_t;

	// saturate a wide signed value to the signed 32-bit range
	function automatic logic signed [SigW-1:0] sat_s32(input logic signed [SumW-1:0] v);
		logic signed [SumW-1:0] max_v;
		logic signed [SumW-1:0] min_v;
		max_v = SumW'({1'b0, {(SigW-1){1'b1}}});
		min_v = -max_v - SumW'(1);
		if (v > max_v) begin
			sat_s32 = {1'b0, {(SigW-1){1'b1}}};
		end else if (v < min_v) begin
			sat_s32 = {1'b1, {(SigW-1){1'b0}}};
		end else begin
			sat_s32 = v[SigW-1:0];
		end
	endfunction

endpackage

[rtl/core/pso_peu_velocity.sv]
// ----------------------------------------------------------------------------
// pso_peu_velocity
// three-stage velocity datapath: products, scaled terms, saturated sum
// ----------------------------------------------------------------------------
module pso_peu_velocity import pso_peu_pkg::*; (
	input  logic                     clk,
	input  pipe_ctrl_t               ctrl,
	input  in_item_t                 item,
	input  logic signed [CoefW-1:0]  inertia_weight,
	input  logic [CoefW-1:0]         cognitive_gain,
	input  logic [CoefW-1:0]         social_gain,
	output vel_item_t                result
);

	// stage 1: w*v, gain*random factors, differences
	logic signed [InProdW-1:0]   wv;
	logic [CoefW+RandW-1:0]      c1r1;
	logic [CoefW+RandW-1:0]      c2r2;
	logic signed [DiffW-1:0]     d1;
	logic signed [DiffW-1:0]     d2;

	logic signed [InProdW-1:0]   wv_s1;
	logic [CoefW-1:0]            f1_s1;
	logic [CoefW-1:0]            f2_s1;
	logic signed [DiffW-1:0]     d1_s1;
	logic signed [DiffW-1:0]     d2_s1;
	logic signed [SigW-1:0]      x_s1;
	logic signed [SigW-1:0]      lo_s1;
	logic signed [SigW-1:0]      hi_s1;
	logic                        last_s1;

	assign wv   = InProdW'(inertia_weight) * InProdW'(item.velocity);
	assign c1r1 = (CoefW+RandW)'(cognitive_gain) * (CoefW+RandW)'(item.rand_one);
	assign c2r2 = (CoefW+RandW)'(social_gain) * (CoefW+RandW)'(item.rand_two);
	assign d1   = DiffW'(item.personal_best) - DiffW'(item.position);
	assign d2   = DiffW'(item.global_best) - DiffW'(item.position);

	always_ff @(posedge clk) begin
		if (ctrl.adv_s1) begin
			wv_s1   <= wv;
			f1_s1   <= c1r1[CoefW+RandW-1:RandW];
			f2_s1   <= c2r2[CoefW+RandW-1:RandW];
			d1_s1   <= d1;
			d2_s1   <= d2;
			x_s1    <= item.position;
			lo_s1   <= item.lower_bound;
			hi_s1   <= item.upper_bound;
			last_s1 <= item.last_element;
		end
	end

	// stage 2: attraction products, all terms shifted down by the weight fraction
	logic signed [AtProdW-1:0]   pc;
	logic signed [AtProdW-1:0]   ps;

	logic signed [InTermW-1:0]   tin_s2;
	logic signed [AtTermW-1:0]   tc_s2;
	logic signed [AtTermW-1:0]   ts_s2;
	logic signed [SigW-1:0]      x_s2;
	logic signed [SigW-1:0]      lo_s2;
	logic signed [SigW-1:0]      hi_s2;
	logic                        last_s2;

	assign pc = $signed({1'b0, f1_s1}) * AtProdW'(d1_s1);
	assign ps = $signed({1'b0, f2_s1}) * AtProdW'(d2_s1);

	always_ff @(posedge clk) begin
		if (ctrl.adv_s2) begin
			tin_s2  <= wv_s1[InProdW-1:FracSh];
			tc_s2   <= pc[AtProdW-1:FracSh];
			ts_s2   <= ps[AtProdW-1:FracSh];
			x_s2    <= x_s1;
			lo_s2   <= lo_s1;
			hi_s2   <= hi_s1;
			last_s2 <= last_s1;
		end
	end

	// stage 3: exact sum, saturated to 32 bits
	logic signed [SumW-1:0] vsum;

	assign vsum = SumW'(tin_s2) + SumW'(tc_s2) + SumW'(ts_s2);

	always_ff @(posedge clk) begin
		if (ctrl.adv_s3) begin
			result.new_velocity <= sat_s32(vsum);
			result.position     <= x_s2;
			result.lower_bound  <= lo_s2;
			result.upper_bound  <= hi_s2;
			result.last_element <= last_s2;
		end
	end

endmodule

[rtl/core/pso_particle_element_update_unit.sv]
// ----------------------------------------------------------------------------
// pso_particle_element_update_unit
// particle swarm velocity and position update, one dimension per word
// ----------------------------------------------------------------------------
// Takes one element per cycle while the output is not stalled. Four register
// stages sit in the path: gain and inertia multipliers, attraction
// multipliers, velocity sum with saturation, and the position add with clamp
// in the output register. Each stage holds its word while the stage after it
// is full and stalled, so bubbles close up and a stall loses nothing. Weights
// and gains reset to w = 0.7, c1 = c2 = 2.0 in Q4.12; users write them through
// the cfg port only while no element is in flight; the block does not check it.
module pso_particle_element_update_unit import pso_peu_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	// configuration write
	input  logic               cfg_valid,
	output logic               cfg_ready,
	input  logic [CfgIdxW-1:0] cfg_index,
	input  logic [CoefW-1:0]   cfg_data,
	// input elements
	input  logic               s_tvalid,
	output logic               s_tready,
	// position, velocity, personal_best, global_best, rand_one, rand_two,
	// lower_bound, upper_bound
	input  logic [223:0]       s_tdata,
	input  logic               s_tlast,  // last_element
	// results
	output logic               m_tvalid,
	input  logic               m_tready,
	output logic [63:0]        m_tdata,  // new_position, new_velocity
	output logic               m_tlast   // last_out
);

	logic signed [CoefW-1:0] inertia_q;
	logic [CoefW-1:0]        cog_q;
	logic [CoefW-1:0]        soc_q;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			inertia_q <= InertiaRst;
			cog_q     <= CogRst;
			soc_q     <= SocRst;
		end else if (cfg_valid && cfg_ready) begin
			// unmapped indexes are dropped
			unique case (cfg_index)
				REG_INERTIA: begin
					inertia_q <= cfg_data;
				end
				REG_COG: begin
					cog_q <= cfg_data;
				end
				REG_SOC: begin
					soc_q <= cfg_data;
				end
				default: begin
				end
			endcase
		end
	end

	// valid bits and stage advance
	logic       valid_s1, valid_s2, valid_s3, valid_s4;
	logic       adv_s4;
	pipe_ctrl_t ctrl;

	assign adv_s4      = !valid_s4 || m_tready;
	assign ctrl.adv_s3 = !valid_s3 || adv_s4;
	assign ctrl.adv_s2 = !valid_s2 || ctrl.adv_s3;
	assign ctrl.adv_s1 = !valid_s1 || ctrl.adv_s2;
	assign s_tready    = ctrl.adv_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
			valid_s4 <= 1'b0;
		end else begin
			if (ctrl.adv_s1) begin
				valid_s1 <= s_tvalid;
			end
			if (ctrl.adv_s2) begin
				valid_s2 <= valid_s1;
			end
			if (ctrl.adv_s3) begin
				valid_s3 <= valid_s2;
			end
			if (adv_s4) begin
				valid_s4 <= valid_s3;
			end
		end
	end

	in_item_t  item;
	vel_item_t vel_s3;

	assign item.position      = s_tdata[31:0];
	assign item.velocity      = s_tdata[63:32];
	assign item.personal_best = s_tdata[95:64];
	assign item.global_best   = s_tdata[127:96];
	assign item.rand_one      = s_tdata[143:128];
	assign item.rand_two      = s_tdata[159:144];
	assign item.lower_bound   = s_tdata[191:160];
	assign item.upper_bound   = s_tdata[223:192];
	assign item.last_element  = s_tlast;

	pso_peu_velocity u_velocity (
		.clk            (clk),
		.ctrl           (ctrl),
		.item           (item),
		.inertia_weight (inertia_q),
		.cognitive_gain (cog_q),
		.social_gain    (soc_q),
		.result         (vel_s3)
	);

	// stage 4: saturated and clamped position, lower test first
	logic signed [SigW-1:0] xsat;
	logic signed [SigW-1:0] xclamp;
	logic signed [SigW-1:0] pos_s4;
	logic signed [SigW-1:0] vel_s4;
	logic                   last_s4;

	assign xsat = sat_s32(SumW'(vel_s3.position) + SumW'(vel_s3.new_velocity));

	always_comb begin
		priority if (xsat < vel_s3.lower_bound) begin
			xclamp = vel_s3.lower_bound;
		end else if (xsat > vel_s3.upper_bound) begin
			xclamp = vel_s3.upper_bound;
		end else begin
			xclamp = xsat;
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s4) begin
			pos_s4  <= xclamp;
			vel_s4  <= vel_s3.new_velocity;
			last_s4 <= vel_s3.last_element;
		end
	end

	assign m_tvalid = valid_s4;
	assign m_tdata  = {vel_s4, pos_s4};
	assign m_tlast  = last_s4;

	// input only blocked when every stage holds a word
	a_full_when_blocked: assert property (@(posedge clk) disable iff (!arst_n)
		!s_tready |-> (valid_s1 && valid_s2 && valid_s3 && valid_s4))
		else $error("input stalled with a free pipeline stage");

	// clamped position stays inside ordered bounds
	a_clamp_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s3 && (vel_s3.lower_bound <= vel_s3.upper_bound)) |->
		((xclamp >= vel_s3.lower_bound) && (xclamp <= vel_s3.upper_bound)))
		else $error("clamped position outside bounds");

	// an inertia write lands in the register
	a_inertia_write: assert property (@(posedge clk) disable iff (!arst_n)
		(cfg_valid && (cfg_index == REG_INERTIA)) |=> (inertia_q == $past(cfg_data)))
		else $error("inertia weight write lost");

endmodule
